[src/bmt_pkg.sv]
`default_nettype none

package bmt_pkg;

  // Timer bank size and data width
  localparam int NTIMER = 4;
  localparam int DATA_W = 32;

  // Decode fields taken from the offset inside the segment
  localparam int TIMER_SEL_W = 5;
  localparam int REG_SEL_W   = 2;

  // Register codes within one 16-byte timer cell
  localparam logic [REG_SEL_W-1:0] REG_VALUE   = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_PERIOD  = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_RUNNING = 2'd2;
  localparam logic [REG_SEL_W-1:0] REG_IRQ     = 2'd3;

  // Bus write aimed at one timer
  typedef struct packed {
    logic                 en;
    logic [REG_SEL_W-1:0] sel;
    logic [DATA_W-1:0]    data;
  } bmt_wr_t;

  // Registers of one timer after the current tick
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] period;
    logic              run;
    logic              irq;
  } bmt_cell_t;

  // Result of the address decode
  typedef struct packed {
    logic                   hit;
    logic [REG_SEL_W-1:0]   sel;
    logic [TIMER_SEL_W-1:0] timer;
  } bmt_dec_t;

endpackage

`default_nettype wire

[src/bmt_decode.sv]
`default_nettype none

module bmt_decode
  import bmt_pkg::*;
(
  input  wire logic [DATA_W-1:0] address,
  input  wire logic [DATA_W-1:0] segment_base,
  input  wire logic [DATA_W-1:0] segment_size,
  output bmt_dec_t               dec
);

  logic [DATA_W-1:0] addr_w;
  logic [DATA_W:0]   seg_end;
  logic [DATA_W-1:0] offset;

  // Drop the byte lane bits and form the segment end without wrap
  assign addr_w  = {address[DATA_W-1:2], 2'b00};
  assign seg_end = {1'b0, segment_base} + {1'b0, segment_size};
  assign offset  = addr_w - segment_base;

  // Hit when the word address lies in [base, base + size)
  assign dec.hit   = (addr_w >= segment_base) && ({1'b0, addr_w} < seg_end);
  assign dec.sel   = offset[3:2];
  assign dec.timer = offset[8:4];

endmodule

`default_nettype wire

[src/bmt_timer.sv]
`default_nettype none

module bmt_timer
  import bmt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      tick,
  input  wire bmt_wr_t   wr,
  output bmt_cell_t      cell_next
);

  logic [DATA_W-1:0] value;
  logic [DATA_W-1:0] period;
  logic [DATA_W-1:0] count;
  logic              run;
  logic              irq;

  logic [DATA_W-1:0] count_next;
  logic              wr_value;
  logic              wr_period;
  logic              wr_run;
  logic              wr_irq;
  logic              data_nz;
  logic              reload;

  assign wr_value  = wr.en && (wr.sel == REG_VALUE);
  assign wr_period = wr.en && (wr.sel == REG_PERIOD);
  assign wr_run    = wr.en && (wr.sel == REG_RUNNING);
  assign wr_irq    = wr.en && (wr.sel == REG_IRQ);
  assign data_nz   = (wr.data != '0);
  assign reload    = run && (count == '0);

  // Free-running value: a write replaces this tick's increment
  assign cell_next.value  = wr_value ? wr.data : value + DATA_W'(1);
  assign cell_next.period = wr_period ? wr.data : period;

  // Countdown follows the run flag from before the tick
  always_comb begin
    count_next = wr_period ? wr.data : count;
    if (run) begin
      count_next = reload ? period : count - DATA_W'(1);
    end
  end

  assign cell_next.run = wr_period ? 1'b0 : (wr_run ? data_nz : run);
  assign cell_next.irq = reload ? 1'b1 : (wr_irq ? data_nz : irq);

  // Advance the timer once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      value  <= '0;
      period <= '0;
      count  <= '0;
      run    <= 1'b0;
      irq    <= 1'b0;
    end else if (tick) begin
      value  <= cell_next.value;
      period <= cell_next.period;
      count  <= count_next;
      run    <= cell_next.run;
      irq    <= cell_next.irq;
    end
  end

endmodule

`default_nettype wire

[src/bus_multi_timer.sv]
// Timing: an item is registered on acceptance, and its result is registered
//   when the item advances, which waits while the result is stalled.
// Throughput: one item per cycle unless stalled; all timers step together.
// Reset (rst, synchronous): timers, flags, bus phase and pending selection
//   clear; segment base returns to 0 and segment size to 512; no item held.
`default_nettype none

module bus_multi_timer
  import bmt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Input item channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              access_valid,
  input  wire logic              func,
  input  wire logic [DATA_W-1:0] address,
  input  wire logic [DATA_W-1:0] write_data,
  // Result item channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             ack,
  output logic [DATA_W-1:0]      read_data,
  output logic [DATA_W-1:0]      irq_lines,
  // Configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [3:0]        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;
  localparam logic [1:0] PH_ERROR = 2'd3;

  localparam logic [1:0] ACK_NONE  = 2'd0;
  localparam logic [1:0] ACK_READY = 2'd1;
  localparam logic [1:0] ACK_ERROR = 2'd2;

  localparam logic [3:0] CFG_BASE = 4'd0;
  localparam logic [3:0] CFG_SIZE = 4'd1;

  logic [DATA_W-1:0] segment_base;
  logic [DATA_W-1:0] segment_size;

  logic              s1_valid;
  logic              s1_access;
  logic              s1_func;
  logic [DATA_W-1:0] s1_addr;
  logic [DATA_W-1:0] s1_wdata;

  logic [1:0]             phase;
  logic [1:0]             phase_next;
  logic [REG_SEL_W-1:0]   pend_reg;
  logic [REG_SEL_W-1:0]   pend_reg_next;
  logic [TIMER_SEL_W-1:0] pend_timer;
  logic [TIMER_SEL_W-1:0] pend_timer_next;

  logic              adv;
  logic              in_accept;
  bmt_dec_t          dec;
  bmt_wr_t           wr [NTIMER];
  bmt_cell_t         cell_next [NTIMER];
  logic [1:0]        ack_next;
  logic [DATA_W-1:0] rdata_next;
  logic [DATA_W-1:0] lines_next;

  // Handshake: stage one moves on when the result register is free
  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_base <= '0;
      segment_size <= DATA_W'(512);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BASE) begin
        segment_base <= cfg_data;
      end else if (cfg_index == CFG_SIZE) begin
        segment_size <= cfg_data;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_access <= access_valid;
      s1_func   <= func;
      s1_addr   <= address;
      s1_wdata  <= write_data;
    end
  end

  bmt_decode u_decode (
    .address      (s1_addr),
    .segment_base (segment_base),
    .segment_size (segment_size),
    .dec          (dec)
  );

  // Bus phase: decode in idle, any other phase returns to idle
  always_comb begin
    phase_next      = PH_IDLE;
    pend_reg_next   = pend_reg;
    pend_timer_next = pend_timer;
    if ((phase == PH_IDLE) && s1_access) begin
      if (!dec.hit) begin
        phase_next = PH_ERROR;
      end else begin
        pend_reg_next   = dec.sel;
        pend_timer_next = dec.timer;
        phase_next      = s1_func ? PH_READ : PH_WRITE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      pend_reg   <= '0;
      pend_timer <= '0;
    end else if (adv) begin
      phase      <= phase_next;
      pend_reg   <= pend_reg_next;
      pend_timer <= pend_timer_next;
    end
  end

  // Timer bank: the write phase addresses at most one timer
  for (genvar t = 0; t < NTIMER; t++) begin : g_timer
    assign wr[t].en   = (phase == PH_WRITE) && (pend_timer == TIMER_SEL_W'(t));
    assign wr[t].sel  = pend_reg;
    assign wr[t].data = s1_wdata;

    bmt_timer u_timer (
      .clk       (clk),
      .rst       (rst),
      .tick      (adv),
      .wr        (wr[t]),
      .cell_next (cell_next[t])
    );
  end

  // Result: response, read data and irq lines from the updated state
  always_comb begin
    unique case (phase_next)
      PH_READ, PH_WRITE: ack_next = ACK_READY;
      PH_ERROR:          ack_next = ACK_ERROR;
      default:           ack_next = ACK_NONE;
    endcase
    rdata_next = '0;
    lines_next = '0;
    for (int i = 0; i < NTIMER; i++) begin
      if ((phase_next == PH_READ) && (pend_timer_next == TIMER_SEL_W'(i))) begin
        unique case (pend_reg_next)
          REG_VALUE:   rdata_next = cell_next[i].value;
          REG_PERIOD:  rdata_next = cell_next[i].period;
          REG_RUNNING: rdata_next = DATA_W'(cell_next[i].run);
          default:     rdata_next = DATA_W'(cell_next[i].irq);
        endcase
      end
      lines_next[i] = cell_next[i].irq && cell_next[i].run;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ack       <= ack_next;
      read_data <= rdata_next;
      irq_lines <= lines_next;
    end
  end

  // Checks
  a_ack_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((ack == ACK_NONE) || (ack == ACK_READY) || (ack == ACK_ERROR)))
    else $error("undefined ack code");

  a_rdata_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (ack != ACK_READY)) |-> (read_data == '0))
    else $error("read data without ready response");

  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && (phase != PH_IDLE)) |=> (phase == PH_IDLE))
    else $error("bus phase did not return to idle");

  a_irq_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((irq_lines >> NTIMER) == '0))
    else $error("irq line set beyond timer count");

endmodule

`default_nettype wire

[tb/bus_multi_timer_tb.sv]
`timescale 1ns / 100ps

module bus_multi_timer_tb;
  import bmt_pkg::*;

  localparam bit FUNC_WRITE = 1'b0;
  localparam bit FUNC_READ  = 1'b1;

  localparam logic [1:0] ACK_NONE  = 2'd0;
  localparam logic [1:0] ACK_READY = 2'd1;
  localparam logic [1:0] ACK_ERROR = 2'd2;

  localparam logic [3:0] CFG_SEG_BASE = 4'd0;
  localparam logic [3:0] CFG_SEG_SIZE = 4'd1;

  localparam logic [DATA_W-1:0] WORD_MASK = 32'hFFFF_FFFC;

  localparam int NUM_SEGS      = 7;
  localparam int TICKS_PER_SEG = 58;
  localparam int TIMEOUT_NS    = 400000;

  typedef enum logic [1:0] {PH_IDLE, PH_READ, PH_WRITE, PH_ERROR} bus_phase_e;

  typedef struct packed {
    logic [1:0]        ack;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] irqs;
  } timer_resp_t;

  // Timer bank mirror: predicts each response and checks it in order
  class timer_scoreboard;
    logic [DATA_W-1:0]      cfg_base;
    logic [DATA_W-1:0]      cfg_size;
    bus_phase_e             phase;
    logic [REG_SEL_W-1:0]   pend_sel;
    logic [TIMER_SEL_W-1:0] pend_tmr;
    logic [DATA_W-1:0]      free_cnt [NTIMER];
    logic [DATA_W-1:0]      period [NTIMER];
    logic [DATA_W-1:0]      down_cnt [NTIMER];
    bit                     running [NTIMER];
    bit                     irq_flag [NTIMER];
    timer_resp_t            resp_q [$];
    int n_items, n_reads, n_writes, n_errors, n_irq, n_fail;

    function new();
      cfg_base = '0;
      cfg_size = 32'd512;
      phase    = PH_IDLE;
      pend_sel = '0;
      pend_tmr = '0;
      for (int i = 0; i < NTIMER; i++) begin
        free_cnt[i] = '0;
        period[i]   = '0;
        down_cnt[i] = '0;
        running[i]  = 1'b0;
        irq_flag[i] = 1'b0;
      end
      n_items = 0; n_reads = 0; n_writes = 0; n_errors = 0; n_irq = 0; n_fail = 0;
    endfunction

    function void set_config(logic [3:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        CFG_SEG_BASE: cfg_base = val;
        CFG_SEG_SIZE: cfg_size = val;
        default: ;
      endcase
    endfunction

    // Advance the bank by one tick and queue the response it gives
    function void note_tick(bit av, bit fn, logic [DATA_W-1:0] addr,
                            logic [DATA_W-1:0] wd);
      logic [DATA_W-1:0] word_addr;
      logic [DATA_W-1:0] off;
      logic [DATA_W:0]   seg_end;
      bus_phase_e        nxt;
      bit                run_was [NTIMER];
      logic [DATA_W-1:0] cnt_was [NTIMER];
      logic [DATA_W-1:0] per_was [NTIMER];
      bit                val_wr [NTIMER];
      timer_resp_t       r;
      word_addr = addr & WORD_MASK;
      for (int i = 0; i < NTIMER; i++) begin
        run_was[i] = running[i];
        cnt_was[i] = down_cnt[i];
        per_was[i] = period[i];
        val_wr[i]  = 1'b0;
      end

      // Decode in idle, perform the pending write in the write phase
      nxt = PH_IDLE;
      case (phase)
        PH_IDLE: if (av) begin
          seg_end = {1'b0, cfg_base} + {1'b0, cfg_size};
          if (word_addr < cfg_base || {1'b0, word_addr} >= seg_end) begin
            nxt = PH_ERROR;
          end else begin
            off      = word_addr - cfg_base;
            pend_sel = off[3:2];
            pend_tmr = off[8:4];
            nxt      = (fn == FUNC_READ) ? PH_READ : PH_WRITE;
          end
        end
        PH_WRITE: if (pend_tmr < NTIMER) begin
          case (pend_sel)
            REG_VALUE: begin
              free_cnt[pend_tmr] = wd;
              val_wr[pend_tmr]   = 1'b1;
            end
            REG_PERIOD: begin
              period[pend_tmr]   = wd;
              down_cnt[pend_tmr] = wd;
              running[pend_tmr]  = 1'b0;
            end
            REG_RUNNING: running[pend_tmr] = (wd != '0);
            default: irq_flag[pend_tmr] = (wd != '0);
          endcase
        end
        default: ;
      endcase
      phase = nxt;

      // Count up every value; count down timers that were running
      for (int i = 0; i < NTIMER; i++) begin
        if (!val_wr[i]) free_cnt[i] = free_cnt[i] + 1;
        if (run_was[i]) begin
          if (cnt_was[i] != '0) begin
            down_cnt[i] = cnt_was[i] - 1;
          end else begin
            down_cnt[i] = per_was[i];
            irq_flag[i] = 1'b1;
          end
        end
      end

      // Build the response from the updated state
      r = '0;
      case (phase)
        PH_WRITE: begin
          r.ack = ACK_READY;
          n_writes++;
        end
        PH_READ: begin
          r.ack = ACK_READY;
          n_reads++;
          if (pend_tmr < NTIMER) begin
            case (pend_sel)
              REG_VALUE:   r.rdata = free_cnt[pend_tmr];
              REG_PERIOD:  r.rdata = period[pend_tmr];
              REG_RUNNING: r.rdata = {31'b0, running[pend_tmr]};
              default:     r.rdata = {31'b0, irq_flag[pend_tmr]};
            endcase
          end
        end
        PH_ERROR: begin
          r.ack = ACK_ERROR;
          n_errors++;
        end
        default: r.ack = ACK_NONE;
      endcase
      for (int i = 0; i < NTIMER; i++) begin
        if (irq_flag[i] && running[i]) r.irqs[i] = 1'b1;
      end
      if (r.irqs != '0) n_irq++;
      n_items++;
      resp_q.push_back(r);
    endfunction

    function void flag(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
      n_fail++;
      if (n_fail <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
    endfunction

    // Compare one accepted response with the oldest prediction
    function void check_result(logic [1:0] ack_v, logic [DATA_W-1:0] rd_v,
                               logic [DATA_W-1:0] irq_v);
      timer_resp_t e;
      if (resp_q.size() == 0) begin
        flag("unexpected response, ack", '0, {30'b0, ack_v});
        return;
      end
      e = resp_q.pop_front();
      if (ack_v !== e.ack) flag("ack", {30'b0, e.ack}, {30'b0, ack_v});
      if (rd_v !== e.rdata) flag("read_data", e.rdata, rd_v);
      if (irq_v !== e.irqs) flag("irq_lines", e.irqs, irq_v);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              access_valid = 1'b0;
  logic              func = 1'b0;
  logic [DATA_W-1:0] address = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        ack;
  logic [DATA_W-1:0] read_data;
  logic [DATA_W-1:0] irq_lines;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [3:0]        cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  timer_scoreboard   sb;
  int                idle_level = 2;
  logic [DATA_W-1:0] seg_base_tbl [NUM_SEGS];
  logic [DATA_W-1:0] seg_size_tbl [NUM_SEGS];

  bus_multi_timer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .access_valid (access_valid),
    .func         (func),
    .address      (address),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ack          (ack),
    .read_data    (read_data),
    .irq_lines    (irq_lines),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Wait cycles per item; level zero never waits
  function automatic int draw_wait();
    case (idle_level)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  // Highest offset reachable in the segment without passing the top of memory
  function automatic logic [DATA_W-1:0] seg_limit();
    logic [DATA_W-1:0] lim;
    lim = sb.cfg_size - 1;
    if (~sb.cfg_base < lim) lim = ~sb.cfg_base;
    return lim;
  endfunction

  // Offer one tick item and hold it until accepted; enter and leave at negedge
  task automatic send_tick(bit av, bit fn, logic [DATA_W-1:0] addr,
                           logic [DATA_W-1:0] wd);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    access_valid <= av;
    func         <= fn;
    address      <= addr;
    write_data   <= wd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(av, fn, addr, wd);
    @(negedge clk);
  endtask

  // Decode tick followed by the data tick; the second access is ignored
  task automatic bus_access(bit fn, logic [TIMER_SEL_W-1:0] tmr,
                            logic [REG_SEL_W-1:0] sel, logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] off;
    lim      = seg_limit();
    off      = '0;
    off[8:4] = tmr;
    off[3:2] = sel;
    off[1:0] = 2'($urandom_range(0, 3));
    // alias into the upper part of a large segment
    if (lim > 32'd511 && $urandom_range(0, 1) == 1) begin
      off = off | ($urandom_range(0, lim >> 9) << 9);
      if (off > lim) off[31:9] = '0;
    end
    send_tick(1'b1, fn, sb.cfg_base + off, $urandom);
    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, data);
  endtask

  // Mostly well-formed accesses, some idle ticks, some stray addresses
  task automatic random_item(output int used);
    int                     pick;
    logic [DATA_W-1:0]      top;
    logic [TIMER_SEL_W-1:0] tmr;
    logic [REG_SEL_W-1:0]   sel;
    logic [DATA_W-1:0]      d;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      top = seg_limit() >> 4;
      if (top > 31) top = 31;
      tmr = ($urandom_range(0, 4) == 0) ? TIMER_SEL_W'($urandom_range(0, top))
                                        : TIMER_SEL_W'($urandom_range(0, NTIMER - 1));
      sel = REG_SEL_W'($urandom_range(0, 3));
      case (sel)
        REG_VALUE:  d = $urandom;
        REG_PERIOD: d = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 12);
        default:    d = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1);
      endcase
      bus_access(1'($urandom_range(0, 1)), tmr, sel, d);
      used = 2;
    end else if (pick < 85) begin
      send_tick(1'b0, 1'($urandom_range(0, 1)), $urandom, $urandom);
      used = 1;
    end else begin
      send_tick(1'b1, 1'($urandom_range(0, 1)), $urandom, $urandom);
      used = 1;
    end
  endtask

  // Drain all responses, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.resp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Present one register write and hold it until taken; caller drops valid
  task automatic write_cfg(logic [3:0] idx, logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_config(idx, val);
    @(negedge clk);
  endtask

  // Accept responses with random stalls and check each one
  initial begin
    int hold;
    while (rst) @(negedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_result(ack, read_data, irq_lines);
      @(negedge clk);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL bus_multi_timer");
    $finish;
  end

  initial begin
    int n;
    int used;
    sb = new();
    seg_base_tbl = '{32'h0000_0000, 32'h0000_1000, 32'hFFFF_FFF0, 32'h8000_0000,
                     32'hFFFF_FE00, 32'h0000_0000, 32'h1234_5670};
    seg_size_tbl = '{32'h0000_0200, 32'h0000_0040, 32'hFFFF_FFFF, 32'h0000_0010,
                     32'h0000_0400, 32'hFFFF_FFFF, 32'h0000_0200};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset segment
    send_tick(1'b0, FUNC_READ, '0, '0);
    bus_access(FUNC_WRITE, TIMER_SEL_W'(0), REG_PERIOD, 32'd2);
    bus_access(FUNC_WRITE, TIMER_SEL_W'(0), REG_RUNNING, 32'd1);
    bus_access(FUNC_READ, TIMER_SEL_W'(0), REG_IRQ, '0);
    // period write while the timer is still counting
    bus_access(FUNC_WRITE, TIMER_SEL_W'(0), REG_PERIOD, 32'd5);
    bus_access(FUNC_WRITE, TIMER_SEL_W'(1), REG_VALUE, 32'hFFFF_FFFF);
    bus_access(FUNC_READ, TIMER_SEL_W'(1), REG_VALUE, '0);
    // timers past the bank ignore writes and read zero
    bus_access(FUNC_WRITE, TIMER_SEL_W'(5), REG_VALUE, 32'hA5A5_5A5A);
    bus_access(FUNC_READ, TIMER_SEL_W'(31), REG_PERIOD, '0);
    // outside the segment, then an access dropped during the error phase
    send_tick(1'b1, FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(1'b1, FUNC_WRITE, 32'h0000_0004, '0);
    bus_access(FUNC_WRITE, TIMER_SEL_W'(2), REG_IRQ, 32'h8000_0000);
    bus_access(FUNC_WRITE, TIMER_SEL_W'(2), REG_RUNNING, 32'hFFFF_FFFF);
    bus_access(FUNC_READ, TIMER_SEL_W'(2), REG_RUNNING, '0);

    // Random ticks under each segment setting
    for (int p = 0; p < NUM_SEGS; p++) begin
      settle();
      write_cfg(CFG_SEG_BASE, seg_base_tbl[p]);
      write_cfg(CFG_SEG_SIZE, seg_size_tbl[p]);
      cfg_valid  <= 1'b0;
      idle_level = p % 3;
      n = 0;
      while (n < TICKS_PER_SEG) begin
        random_item(used);
        n += used;
      end
    end

    settle();
    $display("Ran %0d ticks over %0d segment settings: %0d reads, %0d writes, %0d errors.",
             sb.n_items, NUM_SEGS, sb.n_reads, sb.n_writes, sb.n_errors);
    $display("%0d responses carried an active irq line; %0d mismatches in total.",
             sb.n_irq, sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("PASS bus_multi_timer");
    end else begin
      $display("FAIL bus_multi_timer");
    end
    $finish;
  end

endmodule
